// ===== rtl/pwrseq_pkg.sv =====
// Shared types and constants for the board power sequencer.
// Depends on nothing; every other file imports it.
package pwrseq_pkg;

   localparam int unsigned REG_W   = 16;
   localparam int unsigned INDEX_W = 2;
   localparam int unsigned CODE_W  = 3;
   localparam int unsigned THERM_W = 2;

   typedef enum logic [6:0] {
      MODE_INIT     = 7'b000_0001,
      MODE_STANDBY  = 7'b000_0010,
      MODE_RAMP     = 7'b000_0100,
      MODE_RUN      = 7'b000_1000,
      MODE_OFF      = 7'b001_0000,
      MODE_OVERHEAT = 7'b010_0000,
      MODE_PWRFAIL  = 7'b100_0000
   } mode_type;

   typedef enum logic [1:0] {
      EV_NONE       = 2'd0,
      EV_INPUT_OK   = 2'd1,
      EV_CRIT_READY = 2'd2,
      EV_CRIT_FAIL  = 2'd3
   } event_type;

   localparam logic [CODE_W-1:0] CODE_INIT     = 3'd0;
   localparam logic [CODE_W-1:0] CODE_STANDBY  = 3'd1;
   localparam logic [CODE_W-1:0] CODE_RAMP     = 3'd2;
   localparam logic [CODE_W-1:0] CODE_RUN      = 3'd3;
   localparam logic [CODE_W-1:0] CODE_OFF      = 3'd4;
   localparam logic [CODE_W-1:0] CODE_OVERHEAT = 3'd5;
   localparam logic [CODE_W-1:0] CODE_PWRFAIL  = 3'd6;

   localparam logic [THERM_W-1:0] THERM_COOL     = 2'd0;
   localparam logic [THERM_W-1:0] THERM_SHUTDOWN = 2'd2;

   localparam logic [INDEX_W-1:0] CSR_RAMP_TIMEOUT    = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_POWERFAIL_DELAY = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_POLL_INTERVAL   = 2'd2;

   localparam logic [REG_W-1:0] RAMP_TIMEOUT_RESET    = 16'd3000;
   localparam logic [REG_W-1:0] POWERFAIL_DELAY_RESET = 16'd3000;
   localparam logic [REG_W-1:0] POLL_INTERVAL_RESET   = 16'd100;

   typedef struct packed {
      logic [REG_W-1:0] ramp_timeout;
      logic [REG_W-1:0] powerfail_delay;
      logic [REG_W-1:0] poll_interval;
   } cfg_type;

   typedef struct packed {
      logic               enable_req;
      logic               input_power_good;
      logic               critical_power_good;
      logic [THERM_W-1:0] thermal_level;
   } tick_type;

   typedef struct packed {
      logic [CODE_W-1:0] power_mode;
      logic              ramp_active;
      logic              monitor_active;
      logic              clear_minmax;
      logic              clear_thermal;
      logic              sensor_poll;
      event_type         event_code;
   } result_type;

   function automatic logic [CODE_W-1:0] mode_code(input mode_type m);
      logic [CODE_W-1:0] c;
      unique case (m)
         MODE_STANDBY:  c = CODE_STANDBY;
         MODE_RAMP:     c = CODE_RAMP;
         MODE_RUN:      c = CODE_RUN;
         MODE_OFF:      c = CODE_OFF;
         MODE_OVERHEAT: c = CODE_OVERHEAT;
         MODE_PWRFAIL:  c = CODE_PWRFAIL;
         default:       c = CODE_INIT;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/pwrseq_req_if.sv =====
// Tick input channel of the power sequencer.
// Depends on pwrseq_pkg for field widths.
interface pwrseq_req_if;
   import pwrseq_pkg::*;
   logic               valid;
   logic               ready;
   logic               enable_req;
   logic               input_power_good;
   logic               critical_power_good;
   logic [THERM_W-1:0] thermal_level;

   modport source(output valid, enable_req, input_power_good, critical_power_good,
                  thermal_level, input ready);
   modport sink(input valid, enable_req, input_power_good, critical_power_good,
                thermal_level, output ready);
endinterface

// ===== rtl/pwrseq_rsp_if.sv =====
// Result channel of the power sequencer.
// Depends on pwrseq_pkg for field widths.
interface pwrseq_rsp_if;
   import pwrseq_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] power_mode;
   logic              ramp_active;
   logic              monitor_active;
   logic              clear_minmax;
   logic              clear_thermal;
   logic              sensor_poll;
   logic [1:0]        event_code;

   modport source(output valid, power_mode, ramp_active, monitor_active, clear_minmax,
                  clear_thermal, sensor_poll, event_code, input ready);
   modport sink(input valid, power_mode, ramp_active, monitor_active, clear_minmax,
                clear_thermal, sensor_poll, event_code, output ready);
endinterface

// ===== rtl/pwrseq_csr_if.sv =====
// Register write channel of the power sequencer.
// Depends on pwrseq_pkg for index and data widths.
interface pwrseq_csr_if;
   import pwrseq_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [REG_W-1:0]   wdata;

   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

// ===== rtl/pwrseq_csr.sv =====
// Configuration registers of the power sequencer.
// Depends on pwrseq_pkg and pwrseq_csr_if.
module pwrseq_csr
   import pwrseq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   pwrseq_csr_if.sink    csr_bus,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_RAMP_TIMEOUT:    cfg_in.ramp_timeout    = csr_bus.wdata;
            CSR_POWERFAIL_DELAY: cfg_in.powerfail_delay = csr_bus.wdata;
            CSR_POLL_INTERVAL:   cfg_in.poll_interval   = csr_bus.wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_timeout    <= RAMP_TIMEOUT_RESET;
         cfg_ff.powerfail_delay <= POWERFAIL_DELAY_RESET;
         cfg_ff.poll_interval   <= POLL_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/pwrseq_step.sv =====
// Next-state and result logic for one tick of the power sequencer.
// Depends on pwrseq_pkg; purely combinational.
module pwrseq_step
   import pwrseq_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = 16
)(
   input  mode_type               mode,
   input  logic [TIMER_WIDTH-1:0] mode_timer,
   input  logic [TIMER_WIDTH-1:0] poll_timer,
   input  cfg_type                cfg,
   input  tick_type               tick,
   output mode_type               mode_next,
   output logic [TIMER_WIDTH-1:0] mode_timer_next,
   output logic [TIMER_WIDTH-1:0] poll_timer_next,
   output result_type             result
);

   localparam int unsigned CMP_W = (TIMER_WIDTH > REG_W) ? TIMER_WIDTH : REG_W;

   logic [TIMER_WIDTH-1:0] mode_inc;
   logic [TIMER_WIDTH-1:0] poll_inc;
   logic                   ramp_expired;
   logic                   fail_expired;
   logic                   poll_due;
   mode_type               cur;
   mode_type               nxt;
   logic                   changed;
   event_type              ev;
   logic                   clr_th;

   assign mode_inc = (&mode_timer) ? mode_timer : mode_timer + TIMER_WIDTH'(1);
   assign poll_inc = (&poll_timer) ? poll_timer : poll_timer + TIMER_WIDTH'(1);

   assign ramp_expired = CMP_W'(mode_inc) > CMP_W'(cfg.ramp_timeout);
   assign fail_expired = CMP_W'(mode_inc) > CMP_W'(cfg.powerfail_delay);
   assign poll_due     = CMP_W'(poll_inc) > CMP_W'(cfg.poll_interval);

   always_comb begin
      cur     = mode;
      changed = 1'b0;
      ev      = EV_NONE;
      clr_th  = 1'b0;
      // Overheat takes over before any other transition is considered.
      if (tick.thermal_level >= THERM_SHUTDOWN && mode != MODE_OVERHEAT) begin
         cur     = MODE_OVERHEAT;
         changed = 1'b1;
      end
      nxt = cur;
      unique case (cur)
         MODE_STANDBY: begin
            if (!tick.enable_req) begin
               nxt = MODE_OFF;
            end else if (tick.input_power_good) begin
               ev  = EV_INPUT_OK;
               nxt = MODE_RAMP;
            end
         end
         MODE_RAMP: begin
            if (!tick.enable_req) begin
               nxt = MODE_OFF;
            end else if (!tick.input_power_good) begin
               nxt = MODE_STANDBY;
            end else if (tick.critical_power_good) begin
               ev  = EV_CRIT_READY;
               nxt = MODE_RUN;
            end else if (ramp_expired) begin
               ev  = EV_CRIT_FAIL;
               nxt = MODE_PWRFAIL;
            end
         end
         MODE_RUN: begin
            if (!tick.enable_req) begin
               nxt = MODE_OFF;
            end else if (!tick.input_power_good) begin
               nxt = MODE_STANDBY;
            end else if (!tick.critical_power_good) begin
               ev  = EV_CRIT_FAIL;
               nxt = MODE_PWRFAIL;
            end
         end
         MODE_OFF: begin
            if (tick.enable_req) begin
               nxt = MODE_STANDBY;
            end
         end
         MODE_OVERHEAT: begin
            if (!tick.enable_req) begin
               clr_th = 1'b1;
               nxt    = MODE_OFF;
            end else if (tick.thermal_level == THERM_COOL) begin
               nxt = MODE_STANDBY;
            end
         end
         MODE_PWRFAIL: begin
            if (!tick.enable_req) begin
               nxt = MODE_OFF;
            end else if (fail_expired) begin
               nxt = MODE_STANDBY;
            end
         end
         default: begin
            nxt = MODE_STANDBY;
         end
      endcase
      if (nxt != cur) begin
         changed = 1'b1;
      end
   end

   assign mode_next       = nxt;
   assign mode_timer_next = changed ? '0 : mode_inc;
   assign poll_timer_next = poll_due ? '0 : poll_inc;

   assign result.power_mode     = mode_code(nxt);
   assign result.ramp_active    = (nxt == MODE_RAMP);
   assign result.monitor_active = (nxt == MODE_RAMP) || (nxt == MODE_RUN);
   assign result.clear_minmax   = !tick.enable_req;
   assign result.clear_thermal  = clr_th;
   assign result.sensor_poll    = poll_due;
   assign result.event_code     = ev;

endmodule

// ===== rtl/power_sequencing_fsm.sv =====
// Board power sequencer: one tick beat in, one result beat out. A beat is
// held in the input register and then offered from the result register;
// throughput is one beat per cycle while the result side keeps up. The mode
// and its timers advance as each tick leaves the input register.
// Depends on pwrseq_pkg, the three channel interfaces, pwrseq_csr and pwrseq_step.
module power_sequencing_fsm
   import pwrseq_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = 16
)(
   input  logic          clock,
   input  logic          reset,
   pwrseq_req_if.sink    req_bus,
   pwrseq_rsp_if.source  rsp_bus,
   pwrseq_csr_if.sink    csr_bus
);

   cfg_type                cfg;
   tick_type               tick_ff;
   logic                   tick_valid_ff;
   logic                   tick_valid_in;
   result_type             result_ff;
   result_type             result_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   mode_type               mode_ff;
   mode_type               mode_in;
   logic [TIMER_WIDTH-1:0] mode_timer_ff;
   logic [TIMER_WIDTH-1:0] mode_timer_in;
   logic [TIMER_WIDTH-1:0] poll_timer_ff;
   logic [TIMER_WIDTH-1:0] poll_timer_in;
   logic                   advance;
   logic                   req_take;

   pwrseq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   pwrseq_step #(.TIMER_WIDTH(TIMER_WIDTH)) u_step (
      .mode            (mode_ff),
      .mode_timer      (mode_timer_ff),
      .poll_timer      (poll_timer_ff),
      .cfg             (cfg),
      .tick            (tick_ff),
      .mode_next       (mode_in),
      .mode_timer_next (mode_timer_in),
      .poll_timer_next (poll_timer_in),
      .result          (result_in)
   );

   assign advance       = tick_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !tick_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign tick_valid_in = req_take || (tick_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_INIT;
         mode_timer_ff <= '0;
         poll_timer_ff <= '0;
      end else begin
         tick_valid_ff <= tick_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            mode_ff       <= mode_in;
            mode_timer_ff <= mode_timer_in;
            poll_timer_ff <= poll_timer_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff.enable_req          <= req_bus.enable_req;
         tick_ff.input_power_good    <= req_bus.input_power_good;
         tick_ff.critical_power_good <= req_bus.critical_power_good;
         tick_ff.thermal_level       <= req_bus.thermal_level;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.power_mode     = result_ff.power_mode;
   assign rsp_bus.ramp_active    = result_ff.ramp_active;
   assign rsp_bus.monitor_active = result_ff.monitor_active;
   assign rsp_bus.clear_minmax   = result_ff.clear_minmax;
   assign rsp_bus.clear_thermal  = result_ff.clear_thermal;
   assign rsp_bus.sensor_poll    = result_ff.sensor_poll;
   assign rsp_bus.event_code     = result_ff.event_code;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for power_sequencing_fsm: directed beats, then random ticks over
// several register settings, mostly with random stalls, each result checked against a
// predictor or a planned value. Depends on pwrseq_pkg and the req, rsp and csr interfaces.
module tb;
   import pwrseq_pkg::*;

   localparam int TIMER_W = 16;
   localparam logic [TIMER_W-1:0] TIMER_TOP = '1;
   localparam int STALL_LIMIT = 1000;
   localparam int PLAN_ROWS = 28;
   localparam logic [INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [THERM_W-1:0] THERM_WARM = 2'd1;
   localparam logic [THERM_W-1:0] THERM_MAX = 2'd3;
   localparam result_type NO_CHECK = '0;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      tick_type           tick;
      logic [INDEX_W-1:0] reg_index;
      logic [REG_W-1:0]   reg_value;
      logic               typed;
      result_type         want;
   } plan_row_type;

   logic clock;
   logic reset;

   pwrseq_req_if req_bus();
   pwrseq_rsp_if rsp_bus();
   pwrseq_csr_if csr_bus();

   power_sequencing_fsm i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   cfg_type            seq_cfg;
   logic [CODE_W-1:0]  seq_mode;
   logic [TIMER_W-1:0] mode_ticks;
   logic [TIMER_W-1:0] poll_ticks;
   result_type         expected_results[$];
   result_type         predicted;
   result_type         got;
   result_type         want;
   logic               pending_typed;
   result_type         pending_want;
   bit                 bursts_on;
   int                 stall_left;
   int                 quiet_cycles;
   int                 ticks_accepted;
   int                 results_checked;
   int                 reg_writes;
   int                 errors;
   plan_row_type       plan [0:PLAN_ROWS-1];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic tick_type make_tick(input logic en, input logic pin, input logic crit,
                                          input logic [THERM_W-1:0] th);
      tick_type t;
      t.enable_req          = en;
      t.input_power_good    = pin;
      t.critical_power_good = crit;
      t.thermal_level       = th;
      return t;
   endfunction

   function automatic plan_row_type beat(input logic en, input logic pin, input logic crit,
                                         input logic [THERM_W-1:0] th);
      plan_row_type r;
      r = '0;
      r.kind = ROW_TICK;
      r.tick = make_tick(en, pin, crit, th);
      return r;
   endfunction

   function automatic plan_row_type checked(input plan_row_type r, input result_type w);
      plan_row_type c;
      c = r;
      c.typed = 1'b1;
      c.want = w;
      return c;
   endfunction

   function automatic plan_row_type reg_write(input logic [INDEX_W-1:0] idx,
                                              input logic [REG_W-1:0] value);
      plan_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.reg_index = idx;
      r.reg_value = value;
      return r;
   endfunction

   function automatic tick_type random_tick();
      tick_type t;
      int roll;
      t.enable_req          = ($urandom_range(99) < 88);
      t.input_power_good    = ($urandom_range(99) < 85);
      t.critical_power_good = ($urandom_range(99) < 40);
      roll = $urandom_range(99);
      if (roll < 75) begin
         t.thermal_level = THERM_COOL;
      end else if (roll < 92) begin
         t.thermal_level = THERM_WARM;
      end else if (roll < 97) begin
         t.thermal_level = THERM_SHUTDOWN;
      end else begin
         t.thermal_level = THERM_MAX;
      end
      return t;
   endfunction

   // Advances the sequencer by one tick and returns the result beat it produces.
   function automatic result_type sequence_tick(input tick_type t);
      result_type r;
      logic [CODE_W-1:0] m;
      logic [CODE_W-1:0] nxt;
      r = '0;
      r.event_code = EV_NONE;
      if (mode_ticks != TIMER_TOP) mode_ticks = mode_ticks + TIMER_W'(1);
      if (poll_ticks != TIMER_TOP) poll_ticks = poll_ticks + TIMER_W'(1);
      m = seq_mode;
      if (t.thermal_level >= THERM_SHUTDOWN && m != CODE_OVERHEAT) begin
         m = CODE_OVERHEAT;
         mode_ticks = '0;
      end
      nxt = m;
      case (m)
         CODE_STANDBY: begin
            if (!t.enable_req) begin
               nxt = CODE_OFF;
            end else if (t.input_power_good) begin
               nxt = CODE_RAMP;
               r.event_code = EV_INPUT_OK;
            end
         end
         CODE_RAMP: begin
            if (!t.enable_req) begin
               nxt = CODE_OFF;
            end else if (!t.input_power_good) begin
               nxt = CODE_STANDBY;
            end else if (t.critical_power_good) begin
               nxt = CODE_RUN;
               r.event_code = EV_CRIT_READY;
            end else if (mode_ticks > seq_cfg.ramp_timeout) begin
               nxt = CODE_PWRFAIL;
               r.event_code = EV_CRIT_FAIL;
            end
         end
         CODE_RUN: begin
            if (!t.enable_req) begin
               nxt = CODE_OFF;
            end else if (!t.input_power_good) begin
               nxt = CODE_STANDBY;
            end else if (!t.critical_power_good) begin
               nxt = CODE_PWRFAIL;
               r.event_code = EV_CRIT_FAIL;
            end
         end
         CODE_OFF: begin
            if (t.enable_req) nxt = CODE_STANDBY;
         end
         CODE_OVERHEAT: begin
            if (!t.enable_req) begin
               nxt = CODE_OFF;
               r.clear_thermal = 1'b1;
            end else if (t.thermal_level == THERM_COOL) begin
               nxt = CODE_STANDBY;
            end
         end
         CODE_PWRFAIL: begin
            if (!t.enable_req) begin
               nxt = CODE_OFF;
            end else if (mode_ticks > seq_cfg.powerfail_delay) begin
               nxt = CODE_STANDBY;
            end
         end
         default: begin
            nxt = CODE_STANDBY;
         end
      endcase
      if (nxt != m) mode_ticks = '0;
      seq_mode = nxt;
      if (poll_ticks > seq_cfg.poll_interval) begin
         r.sensor_poll = 1'b1;
         poll_ticks = '0;
      end
      r.power_mode     = nxt;
      r.ramp_active    = (nxt == CODE_RAMP);
      r.monitor_active = (nxt == CODE_RAMP) || (nxt == CODE_RUN);
      r.clear_minmax   = !t.enable_req;
      return r;
   endfunction

   task automatic report_error(input string what, input result_type w, input result_type g);
      errors++;
      if (errors <= 10) begin
         $display("%0t %s: expected mode %0d ramp %b mon %b clrmm %b clrth %b poll %b ev %0d",
                  $time, what, w.power_mode, w.ramp_active, w.monitor_active,
                  w.clear_minmax, w.clear_thermal, w.sensor_poll, w.event_code);
         $display("%0t %s: actual   mode %0d ramp %b mon %b clrmm %b clrth %b poll %b ev %0d",
                  $time, what, g.power_mode, g.ramp_active, g.monitor_active,
                  g.clear_minmax, g.clear_thermal, g.sensor_poll, g.event_code);
      end
   endtask

   task automatic send_tick(input tick_type t, input logic typed, input result_type w);
      int gap;
      gap = 0;
      if (bursts_on && $urandom_range(99) < 20) gap = $urandom_range(3, 1);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid               <= 1'b1;
      req_bus.enable_req          <= t.enable_req;
      req_bus.input_power_good    <= t.input_power_good;
      req_bus.critical_power_good <= t.critical_power_good;
      req_bus.thermal_level       <= t.thermal_level;
      pending_typed = typed;
      pending_want  = w;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      drain_results();
      write_reg(CSR_RAMP_TIMEOUT, c.ramp_timeout);
      write_reg(CSR_POWERFAIL_DELAY, c.powerfail_delay);
      write_reg(CSR_POLL_INTERVAL, c.poll_interval);
   endtask

   task automatic run_phase(input cfg_type c, input bit quiet, input int count);
      apply_config(c);
      bursts_on = !quiet;
      repeat (count) send_tick(random_tick(), 1'b0, NO_CHECK);
   endtask

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         predicted = sequence_tick(make_tick(req_bus.enable_req, req_bus.input_power_good,
                                             req_bus.critical_power_good,
                                             req_bus.thermal_level));
         expected_results.push_back(pending_typed ? pending_want : predicted);
         ticks_accepted++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.power_mode, rsp_bus.ramp_active, rsp_bus.monitor_active,
                rsp_bus.clear_minmax, rsp_bus.clear_thermal, rsp_bus.sensor_poll,
                rsp_bus.event_code};
         if (expected_results.size() == 0) begin
            report_error("unexpected beat", NO_CHECK, got);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (got !== want) report_error("mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && csr_bus.valid && csr_bus.ready) begin
         reg_writes++;
         case (csr_bus.index)
            CSR_RAMP_TIMEOUT:    seq_cfg.ramp_timeout    = csr_bus.wdata;
            CSR_POWERFAIL_DELAY: seq_cfg.powerfail_delay = csr_bus.wdata;
            CSR_POLL_INTERVAL:   seq_cfg.poll_interval   = csr_bus.wdata;
            default: ;
         endcase
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (bursts_on && !reset && $urandom_range(99) < 15) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(2, 0);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("No beat accepted for %0d cycles.", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      reset                       = 1'b1;
      req_bus.valid               = 1'b0;
      req_bus.enable_req          = 1'b0;
      req_bus.input_power_good    = 1'b0;
      req_bus.critical_power_good = 1'b0;
      req_bus.thermal_level       = THERM_COOL;
      rsp_bus.ready               = 1'b0;
      csr_bus.valid               = 1'b0;
      csr_bus.index               = CSR_RAMP_TIMEOUT;
      csr_bus.wdata               = '0;
      seq_cfg    = '{RAMP_TIMEOUT_RESET, POWERFAIL_DELAY_RESET, POLL_INTERVAL_RESET};
      seq_mode   = CODE_INIT;
      mode_ticks = '0;
      poll_ticks = '0;
      pending_typed   = 1'b0;
      pending_want    = NO_CHECK;
      bursts_on       = 1'b1;
      stall_left      = 0;
      quiet_cycles    = 0;
      ticks_accepted  = 0;
      results_checked = 0;
      reg_writes      = 0;
      errors          = 0;

      plan = '{
         checked(beat(1'b1, 1'b0, 1'b0, THERM_COOL),
                 '{CODE_STANDBY, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE}),
         checked(beat(1'b0, 1'b0, 1'b0, THERM_COOL),
                 '{CODE_OFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, EV_NONE}),
         beat(1'b1, 1'b0, 1'b0, THERM_COOL),
         checked(beat(1'b1, 1'b1, 1'b0, THERM_COOL),
                 '{CODE_RAMP, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, EV_INPUT_OK}),
         checked(beat(1'b1, 1'b1, 1'b1, THERM_COOL),
                 '{CODE_RUN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, EV_CRIT_READY}),
         checked(beat(1'b1, 1'b1, 1'b0, THERM_COOL),
                 '{CODE_PWRFAIL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EV_CRIT_FAIL}),
         reg_write(CSR_RAMP_TIMEOUT, 16'd1),
         reg_write(CSR_POWERFAIL_DELAY, 16'd0),
         reg_write(CSR_POLL_INTERVAL, 16'd0),
         reg_write(CSR_UNUSED, 16'hFFFF),
         beat(1'b1, 1'b0, 1'b0, THERM_COOL),
         beat(1'b1, 1'b1, 1'b0, THERM_COOL),
         beat(1'b1, 1'b1, 1'b0, THERM_WARM),
         beat(1'b1, 1'b1, 1'b1, THERM_COOL),
         beat(1'b1, 1'b0, 1'b1, THERM_COOL),
         beat(1'b1, 1'b1, 1'b0, THERM_COOL),
         beat(1'b1, 1'b1, 1'b0, THERM_COOL),
         beat(1'b1, 1'b1, 1'b0, THERM_COOL),
         beat(1'b0, 1'b1, 1'b1, THERM_COOL),
         beat(1'b1, 1'b1, 1'b1, THERM_MAX),
         beat(1'b1, 1'b1, 1'b1, THERM_WARM),
         beat(1'b0, 1'b0, 1'b0, THERM_SHUTDOWN),
         beat(1'b0, 1'b0, 1'b0, THERM_SHUTDOWN),
         beat(1'b1, 1'b0, 1'b0, THERM_SHUTDOWN),
         beat(1'b1, 1'b0, 1'b0, THERM_COOL),
         beat(1'b1, 1'b1, 1'b1, THERM_COOL),
         beat(1'b1, 1'b1, 1'b1, THERM_COOL),
         beat(1'b0, 1'b1, 1'b1, THERM_COOL)
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].kind == ROW_CSR) begin
            drain_results();
            write_reg(plan[i].reg_index, plan[i].reg_value);
         end else begin
            send_tick(plan[i].tick, plan[i].typed, plan[i].want);
         end
      end

      run_phase('{16'd0, 16'd0, 16'd0}, 1'b0, 400);
      run_phase('{16'd4, 16'd8, 16'd5}, 1'b1, 400);

      // With every register at its maximum, no timeout and no poll can fire.
      apply_config('{16'hFFFF, 16'hFFFF, 16'hFFFF});
      bursts_on = 1'b1;
      send_tick(make_tick(1'b0, 1'b1, 1'b0, THERM_COOL), 1'b0, NO_CHECK);
      send_tick(make_tick(1'b1, 1'b0, 1'b0, THERM_COOL), 1'b0, NO_CHECK);
      send_tick(make_tick(1'b1, 1'b1, 1'b0, THERM_COOL), 1'b0, NO_CHECK);
      repeat (200) begin
         send_tick(make_tick(1'b1, 1'b1, 1'b0, THERM_WARM & THERM_W'($urandom_range(1))),
                   1'b0, NO_CHECK);
      end
      send_tick(make_tick(1'b1, 1'b1, 1'b1, THERM_COOL), 1'b0, NO_CHECK);
      send_tick(make_tick(1'b1, 1'b1, 1'b0, THERM_COOL), 1'b0, NO_CHECK);
      repeat (200) begin
         send_tick(make_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                             THERM_WARM & THERM_W'($urandom_range(1))), 1'b0, NO_CHECK);
      end

      run_phase('{REG_W'($urandom_range(20)), REG_W'($urandom_range(20)),
                  REG_W'($urandom_range(20))}, 1'b0, 400);
      run_phase('{16'd25, 16'd60, 16'd9}, 1'b1, 400);

      drain_results();
      repeat (4) @(posedge clock);
      $display("Accepted %0d ticks and %0d register writes over seven register settings,",
               ticks_accepted, reg_writes);
      $display("register extremes 0 and 65535 included; %0d results compared, %0d errors.",
               results_checked, errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
